/* rtl/assert_macros.svh */
// shared assertion macros for the resampler checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define SLR_ASSERT_GEN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define SLR_ASSERT(lbl, prop, msg) \
  `SLR_ASSERT_GEN(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/slr_pkg.sv */
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants of the stereo linear resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned FRAC_BITS    = 32;
  localparam int unsigned PHASE_W      = 37;
  localparam int unsigned MAX_UP_RATIO = 64;
  localparam int unsigned CNT_W        = $clog2(MAX_UP_RATIO);
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 37;
  localparam int unsigned DIFF_W       = SAMPLE_W + 1;
  localparam int unsigned PROD_W       = DIFF_W + FRAC_BITS + 1;
  localparam int unsigned OFF_W        = PROD_W - FRAC_BITS;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_MIN   = PHASE_ONE / MAX_UP_RATIO;
  localparam logic [PHASE_W-1:0] STEP_MAX   = PHASE_ONE << 4;
  localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_ONE;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 1'b0,
    CFG_PASSTHROUGH = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PASS
  } state_e;

  // one emitted frame entering the lanes
  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

endpackage

`default_nettype wire

/* rtl/slr_in_if.sv */
// ----------------------------------------------------------------------------
// slr_in_if
// Input frame channel: valid/ready handshake with a stereo sample pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slr_in_if;
  logic             valid;
  logic             ready;
  slr_pkg::sample_t left_sample;
  slr_pkg::sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

/* rtl/slr_out_if.sv */
// ----------------------------------------------------------------------------
// slr_out_if
// Output frame channel: valid/ready handshake with interpolated frame and flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slr_out_if;
  logic             valid;
  logic             ready;
  slr_pkg::sample_t left_out;
  slr_pkg::sample_t right_out;
  logic             last_of_run;

  modport source (output valid, output left_out, output right_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

/* rtl/stereo_linear_resampler.sv */
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// Linear-interpolation sample-rate converter for 16-bit stereo frames with a
// 5.32 phase accumulator, two interpolation lanes and a merged output stage.
// ----------------------------------------------------------------------------
//   channel   direction  handshake         payload
//   frame_i   in         valid/ready       left_sample, right_sample
//   frame_o   out        valid/ready       left_out, right_out, last_of_run
//   cfg       in         cfg_we_i only     cfg_idx_i, cfg_data_i
//
// Each input frame emits n output frames, with n from 0 to 64; outside
// passthrough, the priming frame after reset emits none.
// The phase sequencer issues one frame per cycle to both lanes while output is not stalled.
// A result passes the lane product register, then the output register.
// A stalled output register holds both lanes and the frame the sequencer issues.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_linear_resampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [slr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [slr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  slr_in_if.sink                            frame_i,
  slr_out_if.source                         frame_o
);

  slr_pkg::state_e                 state_q, state_d;
  logic [slr_pkg::PHASE_W-1:0]     step_q, step_d;
  logic                            pass_q, pass_d;
  slr_pkg::sample_t                prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  slr_pkg::sample_t                cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic [slr_pkg::PHASE_W-1:0]     phase_q, phase_d;
  logic                            primed_q, primed_d;
  logic [slr_pkg::CNT_W-1:0]       cnt_q, cnt_d;

  logic                            in_ready;
  logic                            in_take;
  logic                            adv;
  logic [slr_pkg::PHASE_W-1:0]     phase_sum;
  logic                            phase_ge_one;
  logic                            sum_ge_one;
  logic                            run_last;
  slr_pkg::issue_t                 issue;
  slr_pkg::sample_t                lane_l_a, lane_r_a;
  logic [slr_pkg::FRAC_BITS-1:0]   lane_frac;
  slr_pkg::sample_t                lane_l_y, lane_r_y;

  assign frame_i.ready = in_ready;
  assign in_take       = frame_i.valid && in_ready;

  // phase arithmetic
  assign phase_sum    = phase_q + step_q;
  assign phase_ge_one = phase_q >= slr_pkg::PHASE_ONE;
  assign sum_ge_one   = phase_sum >= slr_pkg::PHASE_ONE;
  assign run_last     = sum_ge_one
                        || (cnt_q == slr_pkg::CNT_W'(slr_pkg::MAX_UP_RATIO - 1));

  // configuration writes, step clamped to its range
  always_comb begin
    step_d = step_q;
    pass_d = pass_q;
    if (cfg_we_i) begin
      unique case (slr_pkg::cfg_idx_e'(cfg_idx_i))
        slr_pkg::CFG_PHASE_STEP: begin
          if (cfg_data_i < slr_pkg::STEP_MIN) begin
            step_d = slr_pkg::STEP_MIN;
          end else if (cfg_data_i > slr_pkg::STEP_MAX) begin
            step_d = slr_pkg::STEP_MAX;
          end else begin
            step_d = cfg_data_i;
          end
        end
        slr_pkg::CFG_PASSTHROUGH: pass_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slr_pkg::ST_IDLE: begin
        if (in_take) begin
          if (pass_q) begin
            state_d = slr_pkg::ST_PASS;
          end else if (primed_q) begin
            state_d = slr_pkg::ST_RUN;
          end
        end
      end
      slr_pkg::ST_PASS: begin
        if (adv) state_d = slr_pkg::ST_IDLE;
      end
      slr_pkg::ST_RUN: begin
        if (phase_ge_one || (adv && run_last)) state_d = slr_pkg::ST_IDLE;
      end
      default: state_d = slr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    in_ready  = 1'b0;
    issue     = '0;
    lane_l_a  = prev_l_q;
    lane_r_a  = prev_r_q;
    lane_frac = phase_q[slr_pkg::FRAC_BITS-1:0];
    prev_l_d  = prev_l_q;
    prev_r_d  = prev_r_q;
    cur_l_d   = cur_l_q;
    cur_r_d   = cur_r_q;
    phase_d   = phase_q;
    primed_d  = primed_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      slr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_take) begin
          cur_l_d = frame_i.left_sample;
          cur_r_d = frame_i.right_sample;
          cnt_d   = '0;
          // passthrough and the priming frame both store it at once
          if (pass_q || !primed_q) begin
            prev_l_d = frame_i.left_sample;
            prev_r_d = frame_i.right_sample;
            primed_d = 1'b1;
          end
        end
      end
      slr_pkg::ST_PASS: begin
        // both ends equal and zero fraction give the frame unchanged
        lane_l_a  = cur_l_q;
        lane_r_a  = cur_r_q;
        lane_frac = '0;
        issue     = '{valid: 1'b1, last: 1'b1};
      end
      slr_pkg::ST_RUN: begin
        if (phase_ge_one) begin
          // downsampling skip, no frame emitted
          phase_d  = phase_q - slr_pkg::PHASE_ONE;
          prev_l_d = cur_l_q;
          prev_r_d = cur_r_q;
        end else begin
          issue = '{valid: 1'b1, last: run_last};
          if (adv) begin
            cnt_d = cnt_q + 1'b1;
            if (run_last) begin
              phase_d  = sum_ge_one ? phase_sum - slr_pkg::PHASE_ONE : '0;
              prev_l_d = cur_l_q;
              prev_r_d = cur_r_q;
            end else begin
              phase_d = phase_sum;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= slr_pkg::ST_IDLE;
      step_q   <= slr_pkg::STEP_RESET;
      pass_q   <= 1'b1;
      prev_l_q <= '0;
      prev_r_q <= '0;
      phase_q  <= '0;
      primed_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pass_q   <= pass_d;
      prev_l_q <= prev_l_d;
      prev_r_q <= prev_r_d;
      phase_q  <= phase_d;
      primed_q <= primed_d;
      cnt_q    <= cnt_d;
    end
  end

  // current frame holding register
  always_ff @(posedge clk_i) begin
    cur_l_q <= cur_l_d;
    cur_r_q <= cur_r_d;
  end

  // left and right interpolation lanes
  slr_lane u_lane_left (
    .clk_i    (clk_i),
    .en_i     (adv),
    .prev_i   (lane_l_a),
    .cur_i    (cur_l_q),
    .frac_i   (lane_frac),
    .sample_o (lane_l_y)
  );

  slr_lane u_lane_right (
    .clk_i    (clk_i),
    .en_i     (adv),
    .prev_i   (lane_r_a),
    .cur_i    (cur_r_q),
    .frac_i   (lane_frac),
    .sample_o (lane_r_y)
  );

  // output frame assembly
  slr_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .left_i  (lane_l_y),
    .right_i (lane_r_y),
    .adv_o   (adv),
    .frame_o (frame_o)
  );

endmodule

`default_nettype wire

/* rtl/slr_lane.sv */
// ----------------------------------------------------------------------------
// slr_lane
// One channel interpolator: a + floor((b - a) * frac / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_lane (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  slr_pkg::sample_t               prev_i,
  input  slr_pkg::sample_t               cur_i,
  input  logic [slr_pkg::FRAC_BITS-1:0]  frac_i,
  output slr_pkg::sample_t               sample_o
);

  logic signed [slr_pkg::DIFF_W-1:0] diff;
  logic signed [slr_pkg::PROD_W-1:0] prod_d;
  logic signed [slr_pkg::PROD_W-1:0] prod_q;
  slr_pkg::sample_t                  base_q;
  logic signed [slr_pkg::OFF_W-1:0]  off;
  logic signed [slr_pkg::OFF_W-1:0]  sum;

  // difference and product against the unsigned fraction
  assign diff   = {cur_i[slr_pkg::SAMPLE_W-1], cur_i} - {prev_i[slr_pkg::SAMPLE_W-1], prev_i};
  assign prod_d = slr_pkg::PROD_W'(diff) * $signed({1'b0, frac_i});

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      base_q <= prev_i;
    end
  end

  // arithmetic shift gives the floor, result always lies between the samples
  assign off      = prod_q[slr_pkg::PROD_W-1:slr_pkg::FRAC_BITS];
  assign sum      = {{(slr_pkg::OFF_W - slr_pkg::SAMPLE_W){base_q[slr_pkg::SAMPLE_W-1]}}, base_q}
                    + off;
  assign sample_o = sum[slr_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

/* rtl/slr_merge.sv */
// ----------------------------------------------------------------------------
// slr_merge
// Joins the two lane results with the frame flags into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slr_pkg::issue_t   issue_i,
  input  slr_pkg::sample_t  left_i,
  input  slr_pkg::sample_t  right_i,
  output logic              adv_o,
  slr_out_if.source         frame_o
);

  slr_pkg::issue_t  s1_q;
  logic             out_v_q;
  slr_pkg::sample_t left_q;
  slr_pkg::sample_t right_q;
  logic             last_q;

  // pipeline moves whenever the output register is free or drained
  assign adv_o = !out_v_q || frame_o.ready;

  // control flags beside the lane product stage and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv_o) begin
      s1_q    <= issue_i;
      out_v_q <= s1_q.valid;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      left_q  <= left_i;
      right_q <= right_i;
      last_q  <= s1_q.last;
    end
  end

  assign frame_o.valid       = out_v_q;
  assign frame_o.left_out    = left_q;
  assign frame_o.right_out   = right_q;
  assign frame_o.last_of_run = last_q;

endmodule

`default_nettype wire

/* rtl/slr_checker.sv */
// ----------------------------------------------------------------------------
// slr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slr_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input slr_pkg::sample_t out_left_i,
  input slr_pkg::sample_t out_right_i,
  input logic             out_last_i
);

  // a stalled result transaction holds its frame
  `SLR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_left_i) && $stable(out_right_i) && $stable(out_last_i), "stalled output frame changed")

  // input side leaves the ready state only through a transaction
  `SLR_ASSERT(a_ready_kept, in_ready_i && !in_valid_i |=> in_ready_i, "input ready dropped without a transaction")

  // a new result was issued while an input frame was in work
  `SLR_ASSERT(a_out_origin, $rose(out_valid_i) |-> $past(!in_ready_i, 2), "output frame without a frame in work")

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (frame_i.valid),
  .in_ready_i  (frame_i.ready),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .out_left_i  (frame_o.left_out),
  .out_right_i (frame_o.right_out),
  .out_last_i  (frame_o.last_of_run)
);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stereo linear resampler. Input frames go in over
// a valid/ready channel while a software resampler predicts every output frame.
// Output frames are checked in order, field by field. The run covers directed
// corner cases, a long output hold-off and randomized configuration phases,
// with random idle bursts on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import slr_pkg::*;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    last;
  } out_frame_t;

  localparam logic [63:0] ONE = 64'(PHASE_ONE);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  slr_in_if  frame_in();
  slr_out_if frame_out();

  stereo_linear_resampler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_in),
    .frame_o    (frame_out)
  );

  // shadow copy of the block's registers and state
  logic [PHASE_W-1:0] model_step = STEP_RESET;
  logic               model_pass = 1'b1;
  sample_t            hist_left = '0;
  sample_t            hist_right = '0;
  logic [63:0]        phase_acc = '0;
  logic               have_prev = 1'b0;

  out_frame_t awaited_frames[$];
  int         mismatch_count = 0;

  // idle controls shared by the driver and the receiver
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  initial begin
    frame_in.valid        = 1'b0;
    frame_in.left_sample  = '0;
    frame_in.right_sample = '0;
    frame_out.ready       = 1'b1;
  end

  // linear interpolation with floor rounding of the offset
  function automatic sample_t lerp(sample_t a, sample_t b, logic [31:0] frac);
    logic signed [63:0] a_ext;
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    a_ext = 64'(a);
    diff  = 64'(b);
    diff  = diff - a_ext;
    prod  = diff * $signed({32'd0, frac});
    sum   = a_ext + (prod >>> FRAC_BITS);
    return sum[SAMPLE_W-1:0];
  endfunction

  // advance the shadow resampler by one input frame, queue what it emits
  function automatic void resample_frame(sample_t l, sample_t r);
    int         n;
    out_frame_t f;
    n = 0;
    if (model_pass) begin
      f.left  = l;
      f.right = r;
      f.last  = 1'b1;
      awaited_frames.push_back(f);
    end else if (have_prev) begin
      while (phase_acc < ONE && n < MAX_UP_RATIO) begin
        f.left  = lerp(hist_left, l, phase_acc[31:0]);
        f.right = lerp(hist_right, r, phase_acc[31:0]);
        n++;
        phase_acc = phase_acc + 64'(model_step);
        f.last = (phase_acc >= ONE) || (n == MAX_UP_RATIO);
        awaited_frames.push_back(f);
      end
      if (phase_acc >= ONE) phase_acc = phase_acc - ONE;
      else phase_acc = '0;
    end
    hist_left  = l;
    hist_right = r;
    have_prev  = 1'b1;
  endfunction

  // register write, shadow copy follows with the step clamped to range
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PHASE_STEP) begin
      if (data < STEP_MIN) model_step = STEP_MIN;
      else if (data > STEP_MAX) model_step = STEP_MAX;
      else model_step = data;
    end else begin
      model_pass = data[0];
    end
    @(posedge clk_i);
  endtask

  // offer one frame, return at the edge where the transaction completes
  task automatic send_frame(sample_t l, sample_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      frame_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    frame_in.valid        <= 1'b1;
    frame_in.left_sample  <= l;
    frame_in.right_sample <= r;
    @(posedge clk_i);
    while (!frame_in.ready) @(posedge clk_i);
    resample_frame(l, r);
  endtask

  // stop offering, wait for every awaited frame plus the block's latency
  task automatic wait_for_drain();
    frame_in.valid <= 1'b0;
    while (awaited_frames.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly mild ratios, sometimes the extremes or a raw 37-bit value
  function automatic logic [CFG_DATA_W-1:0] rand_step();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = 64'(STEP_MIN);
      1: v = 64'(STEP_MAX);
      2: v = {27'd0, 5'($urandom_range(0, 31)), 32'($urandom)};
      3, 4: v = (64'($urandom_range(1, 64)) << 26) + 64'($urandom_range(0, 67108863));
      default: v = (64'($urandom_range(32, 192)) << 26) + 64'($urandom_range(0, 67108863));
    endcase
    return v[CFG_DATA_W-1:0];
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        frame_out.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        frame_out.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        frame_out.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        frame_out.ready <= 1'b1;
      end else begin
        frame_out.ready <= 1'b1;
      end
    end
  end

  // compare each output transaction with the oldest awaited frame
  always @(posedge clk_i) begin : check_outputs
    out_frame_t want;
    if (rst_ni && frame_out.valid && frame_out.ready) begin
      if (awaited_frames.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected frame L=%0d R=%0d last=%0b", $time,
                 frame_out.left_out, frame_out.right_out, frame_out.last_of_run);
      end else begin
        want = awaited_frames.pop_front();
        if (want.left !== frame_out.left_out || want.right !== frame_out.right_out ||
            want.last !== frame_out.last_of_run) begin
          mismatch_count++;
          $display("%0t: expected L=%0d R=%0d last=%0b, actual L=%0d R=%0d last=%0b",
                   $time, want.left, want.right, want.last, frame_out.left_out,
                   frame_out.right_out, frame_out.last_of_run);
        end
      end
    end
  end

  // first frame after reset primes, then unity ratio repeats the previous frame
  task automatic test_priming_unity();
    write_reg(CFG_PASSTHROUGH, '0);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, 16'shffff);
    send_frame(16'sh0001, 16'sh0000);
    wait_for_drain();
  endtask

  // frames copied straight through, phase left alone
  task automatic test_passthrough();
    write_reg(CFG_PASSTHROUGH, 37'd1);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'shffff, 16'sh0001);
    wait_for_drain();
  endtask

  // smallest step: the full burst per frame, with full-scale swings both ways
  task automatic test_step_min();
    write_reg(CFG_PASSTHROUGH, '0);
    write_reg(CFG_PHASE_STEP, '0);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh7fff, 16'sh8000);
    wait_for_drain();
    write_reg(CFG_PHASE_STEP, STEP_MIN);
    send_frame(16'sh8000, 16'sh7fff);
    wait_for_drain();
  endtask

  // largest step: most frames emit nothing, step above range is clamped
  task automatic test_step_max();
    write_reg(CFG_PHASE_STEP, '1);
    send_frame(16'sh1234, 16'shedcb);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, 16'sh0000);
    wait_for_drain();
    write_reg(CFG_PHASE_STEP, STEP_MAX);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh4000, 16'shc000);
    send_frame(16'shc000, 16'sh4000);
    wait_for_drain();
  endtask

  // non-integer ratio, exercises floor on negative differences
  task automatic test_fractional_step();
    write_reg(CFG_PHASE_STEP, 37'h0_6000_0001);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0003, 16'shfffd);
    wait_for_drain();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    write_reg(CFG_PHASE_STEP, 37'h0_4000_0000);
    hold_cycles = 400;
    repeat (30) send_frame(rand_sample(), rand_sample());
    wait_for_drain();
  endtask

  task automatic run_random_phase(int count, bit idle);
    write_reg(CFG_PHASE_STEP, rand_step());
    write_reg(CFG_PASSTHROUGH, ($urandom_range(0, 7) == 0) ? 37'd1 : 37'd0);
    gaps_on   = idle && ($urandom_range(0, 3) != 0);
    stalls_on = idle && ($urandom_range(0, 3) != 0);
    repeat (count) send_frame(rand_sample(), rand_sample());
    wait_for_drain();
  endtask

  task automatic test_random();
    repeat (8) run_random_phase(30, 1'b1);
    run_random_phase(30, 1'b0);
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_priming_unity();
    test_passthrough();
    test_step_min();
    test_step_max();
    test_fractional_step();
    gaps_on = 1'b0;
    test_backpressure();
    test_random();
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* stereo_linear_resampler.f */
+incdir+rtl
rtl/slr_pkg.sv
rtl/slr_in_if.sv
rtl/slr_out_if.sv
rtl/slr_lane.sv
rtl/slr_merge.sv
rtl/stereo_linear_resampler.sv
rtl/slr_checker.sv
test/testbench.sv
